### sv/itp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg: shared constants for the interval timer port block
// Item kinds, port select codes and access kinds of the control byte.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int unsigned NumChannels = 3;

  // Item kinds.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // The control port; lower codes are channel data ports.
  localparam logic [1:0] PORT_CTRL = 2'd3;

  // Access kinds in bits 5..4 of a control byte.
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW   = 2'd1;
  localparam logic [1:0] ACC_HIGH  = 2'd2;
  localparam logic [1:0] ACC_WORD  = 2'd3;

  typedef logic [15:0] count_t;

endpackage

`default_nettype wire

### sv/interval_timer_ports.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interval_timer_ports: three-channel interval timer behind four byte ports
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, mode_i,          | into block
//           | port_sel_i, data_i                       |
//   out     | out_valid_o, out_ready_i, read_data_o,   | out of block
//           | wrap_flags_o                             |
//
// An accepted transaction sits in the input register, is executed against the
// channel state once the output can take it, and its result lands in the
// output register. One transaction is accepted per cycle while the output
// is not stalled; the rate is set by the state update of the execute step.
// A stall on the output holds both registers; the input register keeps
// accepting while it is empty. Reset clears all counters and channel state.
// ----------------------------------------------------------------------------
module interval_timer_ports
  import itp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [1:0] port_sel_i,
  input  wire logic [7:0] data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o,
  output logic [2:0]      wrap_flags_o
);

  // Input register.
  logic       in_vld_q;
  logic [1:0] mode_q;
  logic [1:0] port_q;
  logic [7:0] data_q;

  // Output register.
  logic       out_vld_q;
  logic [7:0] rd_q, rd_d;
  logic [2:0] wrap_q, wrap_d;

  // Channel state.
  count_t     reload_value_q [NumChannels];
  count_t     reload_value_d [NumChannels];
  count_t     live_count_q   [NumChannels];
  count_t     live_count_d   [NumChannels];
  logic [1:0] access_kind_q  [NumChannels];
  logic [1:0] access_kind_d  [NumChannels];
  logic [2:0] count_mode_q   [NumChannels];
  logic [2:0] count_mode_d   [NumChannels];
  logic       write_phase_q  [NumChannels];
  logic       write_phase_d  [NumChannels];
  logic       read_phase_q   [NumChannels];
  logic       read_phase_d   [NumChannels];
  count_t     write_hold_q   [NumChannels];
  count_t     write_hold_d   [NumChannels];
  logic       latch_valid_q  [NumChannels];
  logic       latch_valid_d  [NumChannels];
  count_t     latch_value_q  [NumChannels];
  count_t     latch_value_d  [NumChannels];

  logic exec;

  assign exec       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || exec;

  assign out_valid_o  = out_vld_q;
  assign read_data_o  = rd_q;
  assign wrap_flags_o = wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      port_q <= port_sel_i;
      data_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (exec) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rd_q   <= rd_d;
      wrap_q <= wrap_d;
    end
  end

  // Execute one transaction against the channel state.
  always_comb begin
    logic [1:0] ctl_ch;
    logic [1:0] ctl_acc;
    count_t     hold;
    count_t     src;
    logic       done;
    logic       phase;

    ctl_ch  = data_q[7:6];
    ctl_acc = data_q[5:4];
    hold    = '0;
    src     = '0;
    done    = 1'b0;
    phase   = 1'b0;
    rd_d    = '0;
    wrap_d  = '0;

    for (int c = 0; c < NumChannels; c++) begin
      reload_value_d[c] = reload_value_q[c];
      live_count_d[c]   = live_count_q[c];
      access_kind_d[c]  = access_kind_q[c];
      count_mode_d[c]   = count_mode_q[c];
      write_phase_d[c]  = write_phase_q[c];
      read_phase_d[c]   = read_phase_q[c];
      write_hold_d[c]   = write_hold_q[c];
      latch_valid_d[c]  = latch_valid_q[c];
      latch_value_d[c]  = latch_value_q[c];
    end

    if (exec) begin
      case (mode_q)
        MODE_TICK: begin
          for (int c = 0; c < NumChannels; c++) begin
            if (live_count_q[c] == 16'd1) begin
              live_count_d[c] = reload_value_q[c];
              wrap_d[c]       = 1'b1;
            end else begin
              live_count_d[c] = live_count_q[c] - 16'd1;
            end
          end
        end
        MODE_WRITE: begin
          for (int c = 0; c < NumChannels; c++) begin
            if (port_q == PORT_CTRL) begin
              if (ctl_ch == 2'(c)) begin
                if (ctl_acc == ACC_LATCH) begin
                  latch_value_d[c] = live_count_q[c];
                  latch_valid_d[c] = 1'b1;
                  read_phase_d[c]  = 1'b0;
                end else begin
                  access_kind_d[c] = ctl_acc;
                  count_mode_d[c]  = data_q[3:1];
                  write_phase_d[c] = 1'b0;
                  read_phase_d[c]  = 1'b0;
                  latch_valid_d[c] = 1'b0;
                end
              end
            end else if (port_q == 2'(c)) begin
              // Access kind zero behaves like low-then-high.
              case (access_kind_q[c])
                ACC_LOW: begin
                  hold = {8'h00, data_q};
                  done = 1'b1;
                end
                ACC_HIGH: begin
                  hold = {data_q, 8'h00};
                  done = 1'b1;
                end
                default: begin
                  if (!write_phase_q[c]) begin
                    hold             = {write_hold_q[c][15:8], data_q};
                    write_phase_d[c] = 1'b1;
                  end else begin
                    hold             = {data_q, write_hold_q[c][7:0]};
                    write_phase_d[c] = 1'b0;
                    done             = 1'b1;
                  end
                end
              endcase
              write_hold_d[c] = hold;
              if (done) begin
                reload_value_d[c] = hold;
                live_count_d[c]   = hold;
              end
            end
          end
        end
        MODE_READ: begin
          for (int c = 0; c < NumChannels; c++) begin
            if (port_q == 2'(c)) begin
              src   = latch_valid_q[c] ? latch_value_q[c] : live_count_q[c];
              phase = read_phase_q[c];
              case (access_kind_q[c])
                ACC_LOW:  rd_d = src[7:0];
                ACC_HIGH: rd_d = src[15:8];
                default: begin
                  rd_d  = read_phase_q[c] ? src[15:8] : src[7:0];
                  phase = !read_phase_q[c];
                end
              endcase
              read_phase_d[c] = phase;
              // Word access keeps the latch until the high byte is read.
              if (access_kind_q[c] != ACC_WORD || !phase) begin
                latch_valid_d[c] = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChannels; c++) begin
        reload_value_q[c] <= '0;
        live_count_q[c]   <= '0;
        access_kind_q[c]  <= ACC_LATCH;
        count_mode_q[c]   <= '0;
        write_phase_q[c]  <= 1'b0;
        read_phase_q[c]   <= 1'b0;
        write_hold_q[c]   <= '0;
        latch_valid_q[c]  <= 1'b0;
        latch_value_q[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < NumChannels; c++) begin
        reload_value_q[c] <= reload_value_d[c];
        live_count_q[c]   <= live_count_d[c];
        access_kind_q[c]  <= access_kind_d[c];
        count_mode_q[c]   <= count_mode_d[c];
        write_phase_q[c]  <= write_phase_d[c];
        read_phase_q[c]   <= read_phase_d[c];
        write_hold_q[c]   <= write_hold_d[c];
        latch_valid_q[c]  <= latch_valid_d[c];
        latch_value_q[c]  <= latch_value_d[c];
      end
    end
  end

  // Only a tick can report a wrap.
  a_wrap_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && mode_q != MODE_TICK |=> wrap_flags_o == 3'd0)
    else $error("wrap flag reported for a non-tick transaction");

  // Only a read can return data.
  a_data_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && mode_q != MODE_READ |=> read_data_o == 8'd0)
    else $error("read data returned for a non-read transaction");

  // A counter standing at one takes its reload value on a tick.
  a_reload_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && mode_q == MODE_TICK && live_count_q[0] == 16'd1 |=>
    live_count_q[0] == $past(reload_value_q[0]) && wrap_flags_o[0])
    else $error("channel 0 did not reload on wrap");

  // Input stalls only while both registers are full and the output is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

  // A tick never changes a reload value.
  a_tick_keeps_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && mode_q == MODE_TICK |=> $stable(reload_value_q[0]))
    else $error("reload value changed on a tick");

endmodule

`default_nettype wire

### tb/interval_timer_ports_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interval_timer_ports_tb: self-checking bench for the interval timer ports
// Drives ticks, port writes and port reads through the valid/ready input
// channel with random gaps and output stalls. A behavioral copy of the three
// timer channels predicts every result, and each result is compared in order.
// ----------------------------------------------------------------------------
module interval_timer_ports_tb;
  import itp_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [1:0] ChanNone   = 2'd3;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomItems  = 950;
  localparam int unsigned DrainCycles  = 8;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [2:0] wraps;
  } timer_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] mode_i = MODE_TICK;
  logic [1:0] port_sel_i = 2'd0;
  logic [7:0] data_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] read_data_o;
  logic [2:0] wrap_flags_o;

  // Predicted channel state.
  count_t     reload_val [NumChannels];
  count_t     live_cnt   [NumChannels];
  count_t     wr_hold    [NumChannels];
  count_t     latch_cnt  [NumChannels];
  logic [1:0] acc_kind   [NumChannels];
  logic [2:0] cnt_mode   [NumChannels];
  logic       wr_phase   [NumChannels];
  logic       rd_phase   [NumChannels];
  logic       latched    [NumChannels];

  timer_result_t pending_results[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned wrap_results = 0;
  int unsigned stall_left = 0;
  bit          gap_enable = 1'b1;
  bit          stall_enable = 1'b1;

  interval_timer_ports dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .port_sel_i  (port_sel_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .wrap_flags_o(wrap_flags_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_gap();
    if (!gap_enable || $urandom_range(0, 99) < 55) return 0;
    return pick_len();
  endfunction

  function automatic logic [7:0] ctrl_byte(input logic [1:0] chan, input logic [1:0] acc,
                                           input logic [2:0] cmode, input logic lsb);
    return {chan, acc, cmode, lsb};
  endfunction

  // Applies one transaction to the predicted state and returns its result.
  function automatic timer_result_t timer_step(input logic [1:0] kind,
                                               input logic [1:0] port_id,
                                               input logic [7:0] wr_byte);
    timer_result_t res;
    int unsigned   ch;
    count_t        cur;
    logic          done;
    res = '0;
    done = 1'b0;
    case (kind)
      MODE_TICK: begin
        for (int c = 0; c < NumChannels; c++) begin
          if (live_cnt[c] == 16'd1) begin
            live_cnt[c] = reload_val[c];
            res.wraps[c] = 1'b1;
          end else begin
            live_cnt[c] = live_cnt[c] - 16'd1;
          end
        end
      end
      MODE_WRITE: begin
        if (port_id == PORT_CTRL) begin
          ch = wr_byte[7:6];
          if (wr_byte[7:6] != ChanNone && ch < NumChannels) begin
            if (wr_byte[5:4] == ACC_LATCH) begin
              latch_cnt[ch] = live_cnt[ch];
              latched[ch] = 1'b1;
              rd_phase[ch] = 1'b0;
            end else begin
              acc_kind[ch] = wr_byte[5:4];
              cnt_mode[ch] = wr_byte[3:1];
              wr_phase[ch] = 1'b0;
              rd_phase[ch] = 1'b0;
              latched[ch] = 1'b0;
            end
          end
        end else if (port_id < NumChannels) begin
          ch = port_id;
          if (acc_kind[ch] == ACC_LOW) begin
            wr_hold[ch] = {8'h00, wr_byte};
            done = 1'b1;
          end else if (acc_kind[ch] == ACC_HIGH) begin
            wr_hold[ch] = {wr_byte, 8'h00};
            done = 1'b1;
          end else if (!wr_phase[ch]) begin
            wr_hold[ch][7:0] = wr_byte;
            wr_phase[ch] = 1'b1;
          end else begin
            wr_hold[ch][15:8] = wr_byte;
            wr_phase[ch] = 1'b0;
            done = 1'b1;
          end
          if (done) begin
            reload_val[ch] = wr_hold[ch];
            live_cnt[ch] = wr_hold[ch];
          end
        end
      end
      MODE_READ: begin
        if (port_id != PORT_CTRL && port_id < NumChannels) begin
          ch = port_id;
          cur = latched[ch] ? latch_cnt[ch] : live_cnt[ch];
          if (acc_kind[ch] == ACC_LOW) begin
            res.read_byte = cur[7:0];
          end else if (acc_kind[ch] == ACC_HIGH) begin
            res.read_byte = cur[15:8];
          end else begin
            res.read_byte = rd_phase[ch] ? cur[15:8] : cur[7:0];
            rd_phase[ch] = ~rd_phase[ch];
          end
          // In word access the latch survives until the high byte is read.
          if (acc_kind[ch] != ACC_WORD || !rd_phase[ch]) latched[ch] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Must be called at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_item(input logic [1:0] kind, input logic [1:0] port_id,
                           input logic [7:0] wr_byte);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= kind;
    port_sel_i <= port_id;
    data_i <= wr_byte;
    pending_results.push_back(timer_step(kind, port_id, wr_byte));
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (kind == MODE_TICK) ticks_sent++;
    if (kind == MODE_READ) reads_sent++;
  endtask

  // Output side back-pressure.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else if (stall_enable && $urandom_range(0, 99) < 20) begin
      out_ready_i <= 1'b0;
      stall_left = pick_len() - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    timer_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_data %0h wrap_flags %0b", read_data_o, wrap_flags_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (read_data_o !== exp_res.read_byte) begin
          $error("read_data: expected %0h, got %0h", exp_res.read_byte, read_data_o);
          error_count++;
        end
        if (wrap_flags_o !== exp_res.wraps) begin
          $error("wrap_flags: expected %0b, got %0b", exp_res.wraps, wrap_flags_o);
          error_count++;
        end
        if (exp_res.wraps != 3'b000) wrap_results++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // After reset the access kind is zero, so reads and writes pair up low/high.
  task automatic test_power_up_access();
    send_item(MODE_TICK, 2'd0, 8'h00);
    send_item(MODE_READ, 2'd0, 8'h00);
    send_item(MODE_READ, 2'd0, 8'hFF);
    send_item(MODE_WRITE, 2'd2, 8'h01);
    send_item(MODE_WRITE, 2'd2, 8'h00);
  endtask

  // Reload of one wraps on every tick; reload of two on every other tick.
  task automatic test_wrap_reload();
    send_item(MODE_TICK, 2'd1, 8'h00);
    send_item(MODE_WRITE, PORT_CTRL, ctrl_byte(2'd1, ACC_LOW, 3'b111, 1'b1));
    send_item(MODE_WRITE, 2'd1, 8'h02);
    send_item(MODE_TICK, 2'd0, 8'h00);
    send_item(MODE_TICK, 2'd2, 8'h00);
  endtask

  task automatic test_high_byte_latch();
    send_item(MODE_WRITE, PORT_CTRL, ctrl_byte(2'd0, ACC_HIGH, 3'b000, 1'b0));
    send_item(MODE_WRITE, 2'd0, 8'hFF);
    send_item(MODE_WRITE, PORT_CTRL, ctrl_byte(2'd0, ACC_LATCH, 3'b000, 1'b0));
    send_item(MODE_TICK, 2'd0, 8'h00);
    send_item(MODE_READ, 2'd0, 8'h00);
  endtask

  task automatic test_word_latch();
    send_item(MODE_WRITE, PORT_CTRL, ctrl_byte(2'd0, ACC_WORD, 3'b010, 1'b0));
    send_item(MODE_WRITE, PORT_CTRL, ctrl_byte(2'd0, ACC_LATCH, 3'b000, 1'b0));
    send_item(MODE_TICK, 2'd0, 8'h00);
    send_item(MODE_READ, 2'd0, 8'h00);
    send_item(MODE_READ, 2'd0, 8'h00);
  endtask

  // Ignored control byte, control port read, unused kind, reload of zero.
  task automatic test_ignored_items();
    send_item(MODE_WRITE, PORT_CTRL, ctrl_byte(ChanNone, ACC_WORD, 3'b011, 1'b0));
    send_item(MODE_READ, PORT_CTRL, 8'h00);
    send_item(ModeUnused, PORT_CTRL, 8'hAA);
    send_item(MODE_WRITE, 2'd0, 8'h00);
    send_item(MODE_WRITE, 2'd0, 8'h00);
  endtask

  // Mostly well-formed programming sequences with ticks and reads in between.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    logic [1:0]  ch;
    logic [1:0]  acc;
    count_t      reload;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      gap_enable = $urandom_range(0, 3) != 0;
      stall_enable = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 99);
      ch = 2'($urandom_range(0, NumChannels - 1));
      if (pick < 40) begin
        acc = ($urandom_range(0, 9) < 2) ? ACC_HIGH : 2'($urandom_range(1, 3));
        if ($urandom_range(0, 99) < 70) reload = count_t'($urandom_range(1, 12));
        else if ($urandom_range(0, 9) < 8) reload = count_t'($urandom_range(0, 65535));
        else reload = 16'd0;
        send_item(MODE_WRITE, PORT_CTRL,
                  ctrl_byte(ch, acc, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
        if (acc == ACC_LOW) begin
          send_item(MODE_WRITE, ch, reload[7:0]);
        end else if (acc == ACC_HIGH) begin
          send_item(MODE_WRITE, ch, reload[15:8]);
        end else begin
          send_item(MODE_WRITE, ch, reload[7:0]);
          // Now and then the high byte never comes.
          if ($urandom_range(0, 9) != 0) send_item(MODE_WRITE, ch, reload[15:8]);
        end
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 10)) send_item(MODE_TICK, 2'($urandom_range(0, 3)),
                                                 8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        send_item(MODE_WRITE, PORT_CTRL,
                  ctrl_byte(ch, ACC_LATCH, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 1)) send_item(MODE_TICK, 2'd0, 8'h00);
        repeat ($urandom_range(1, 3)) send_item(MODE_READ, ch, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        send_item(MODE_READ, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    for (int c = 0; c < NumChannels; c++) begin
      reload_val[c] = '0;
      live_cnt[c] = '0;
      wr_hold[c] = '0;
      latch_cnt[c] = '0;
      acc_kind[c] = ACC_LATCH;
      cnt_mode[c] = '0;
      wr_phase[c] = 1'b0;
      rd_phase[c] = 1'b0;
      latched[c] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_up_access();
    test_wrap_reload();
    test_high_byte_latch();
    test_word_latch();
    test_ignored_items();
    test_random_traffic(RandomItems);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d transactions (%0d ticks, %0d reads) under random gaps and stalls.",
             items_sent, ticks_sent, reads_sent);
    $display("%0d results carried a wrap flag; %0d mismatches found.",
             wrap_results, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
